// File: design/weighted_count_selector_defines.svh
// ----------------------------------------------------------------------------
// Weighted count selector assertion macros
// Concurrent check wrappers, compiled away for synthesis.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_COUNT_SELECTOR_DEFINES_SVH
`define WEIGHTED_COUNT_SELECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define WCS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("weighted_count_selector: same-cycle check failed");
// Next-cycle implication
`define WCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("weighted_count_selector: next-cycle check failed");
`else
`define WCS_ASSERT_IMPL(label, ante, cons)
`define WCS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: design/wcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted count selector package
// Sizes and the beat that travels down the row of count cells.
// ----------------------------------------------------------------------------
package wcs_pkg;

    localparam int MAX_GROUPS = 64;
    localparam int COUNT_BITS = 16;

    // Field widths of the ports
    localparam int IDX_W   = 6;
    localparam int CNTIN_W = 16;
    localparam int DRAW_W  = 22;
    localparam int TOTO_W  = 22;
    localparam int RATE_W  = 32;
    localparam int PROP_W  = 54;
    localparam int GRPO_W  = 6;
    localparam int OFFO_W  = 16;

    localparam int POS_W   = $clog2(MAX_GROUPS);
    localparam int TOT_W   = COUNT_BITS + POS_W;
    localparam int CMP_W   = (POS_W > IDX_W) ? POS_W : IDX_W;
    localparam int RC_W    = (COUNT_BITS > DRAW_W) ? COUNT_BITS : DRAW_W;
    localparam int CNTX_W  = (COUNT_BITS > CNTIN_W) ? COUNT_BITS : CNTIN_W;
    localparam int TOTX_W  = (TOT_W > DRAW_W) ? TOT_W : DRAW_W;
    localparam int GRPX_W  = (POS_W > GRPO_W) ? POS_W : GRPO_W;
    localparam int OFFX_W  = (COUNT_BITS > OFFO_W) ? COUNT_BITS : OFFO_W;

    typedef enum logic {
        ACT_SET    = 1'b0,
        ACT_SELECT = 1'b1
    } t_action;

    // One beat walking the cell row
    typedef struct packed {
        logic                  valid;
        t_action               act;
        logic [IDX_W-1:0]      idx;
        logic [COUNT_BITS-1:0] cnt;
        logic [DRAW_W-1:0]     rem;
        logic                  live;   // select still searching
        logic                  found;
        logic                  hit;    // set found its target cell
        logic [POS_W-1:0]      pos;
        logic [POS_W-1:0]      grp;
        logic [COUNT_BITS-1:0] off;
        logic [COUNT_BITS-1:0] old;
    } t_token;

endpackage

// File: design/wcs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted count selector cell
// Holds one group count; updates or searches against it, passes the beat on.
// ----------------------------------------------------------------------------
module wcs_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wcs_pkg::t_token i_tok,
    output wcs_pkg::t_token o_tok
);
    import wcs_pkg::*;

    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    t_token                r_tok;
    t_token                n_tok;
    logic [RC_W-1:0]       w_rem_x;
    logic [RC_W-1:0]       w_cnt_x;
    logic [RC_W-1:0]       w_diff;

    assign w_rem_x = RC_W'(i_tok.rem);
    assign w_cnt_x = RC_W'(r_count);
    assign w_diff  = w_rem_x - w_cnt_x;

    always_comb begin
        n_tok   = i_tok;
        n_count = r_count;
        if (i_tok.valid) begin
            n_tok.pos = i_tok.pos + 1'b1;
            case (i_tok.act)
                ACT_SET: begin
                    if (CMP_W'(i_tok.pos) == CMP_W'(i_tok.idx)) begin
                        n_tok.hit = 1'b1;
                        n_tok.old = r_count;
                        n_count   = i_tok.cnt;
                    end
                end
                ACT_SELECT: begin
                    if (i_tok.live) begin
                        if (w_rem_x < w_cnt_x) begin
                            n_tok.live  = 1'b0;
                            n_tok.found = 1'b1;
                            n_tok.grp   = i_tok.pos;
                            n_tok.off   = w_rem_x[COUNT_BITS-1:0];
                        end else begin
                            n_tok.rem = w_diff[DRAW_W-1:0];
                        end
                    end
                end
                default: begin
                    n_tok = i_tok;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_tok   <= '0;
        end else begin
            r_count <= n_count;
            r_tok   <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: design/weighted_count_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted count selector
// Per-group count table with running total and cumulative-count selection.
// ----------------------------------------------------------------------------
//  channel  | signals                          | beat
//  ---------+----------------------------------+-------------------------------
//  in       | i_valid / o_ready                | action, group, count, draw
//  out      | o_valid / i_ready                | total, propensity, group, ...
//  cfg      | i_cfg_we / i_cfg_wdata           | rate, 16.16 unsigned
//
//  Every beat walks a row of MAX_GROUPS cells, one cell per cycle; the total
//  is then settled into the finish register, and the rate multiply feeds the
//  output register. One beat is in flight at a time.
//  Reset is synchronous, active low, clears all counts and the total, and
//  loads the rate with 1.0 (65536).
//  A result held by a stalled consumer does not block the next input beat.
// ----------------------------------------------------------------------------
module weighted_count_selector (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_action,
    input  logic [wcs_pkg::IDX_W-1:0]   i_group_index,
    input  logic [wcs_pkg::CNTIN_W-1:0] i_group_count,
    input  logic [wcs_pkg::DRAW_W-1:0]  i_draw_value,
    // Result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [wcs_pkg::TOTO_W-1:0]  o_total_count,
    output logic [wcs_pkg::PROP_W-1:0]  o_propensity,
    output logic [wcs_pkg::GRPO_W-1:0]  o_chosen_group,
    output logic [wcs_pkg::OFFO_W-1:0]  o_offset_in_group,
    output logic                        o_draw_error,
    // Rate register
    input  logic                        i_cfg_we,
    input  logic [wcs_pkg::RATE_W-1:0]  i_cfg_wdata
);
    import wcs_pkg::*;

    `include "weighted_count_selector_defines.svh"

    // Control and running state
    logic               r_busy;
    logic [TOT_W-1:0]   r_total;
    logic [TOT_W-1:0]   n_total;
    logic [RATE_W-1:0]  r_rate;

    // Finish stage, between the row exit and the multiply
    logic               r_fin_v;
    logic [TOTO_W-1:0]  r_fin_total;
    logic [GRPO_W-1:0]  r_fin_grp;
    logic [OFFO_W-1:0]  r_fin_off;
    logic               r_fin_err;

    logic               r_out_v;

    logic               w_accept;
    logic               w_move;
    t_token             w_entry;
    t_token             w_link [MAX_GROUPS+1];
    t_token             w_exit;
    logic [CNTX_W-1:0]  w_cnt_x;
    logic [TOTX_W-1:0]  w_draw_x;
    logic [TOTX_W-1:0]  w_total_x;
    logic [TOTX_W-1:0]  w_new_total_x;
    logic [GRPX_W-1:0]  w_grp_x;
    logic [OFFX_W-1:0]  w_off_x;
    logic [PROP_W-1:0]  w_prop;

    assign o_ready  = !r_busy;
    assign w_accept = i_valid && o_ready;

    // Build the beat that enters the row; an out-of-range draw enters dead
    assign w_cnt_x   = CNTX_W'(i_group_count);
    assign w_draw_x  = TOTX_W'(i_draw_value);
    assign w_total_x = TOTX_W'(r_total);

    always_comb begin
        w_entry       = '0;
        w_entry.valid = w_accept;
        w_entry.act   = t_action'(i_action);
        w_entry.idx   = i_group_index;
        w_entry.cnt   = w_cnt_x[COUNT_BITS-1:0];
        w_entry.rem   = i_draw_value;
        w_entry.live  = (t_action'(i_action) == ACT_SELECT) && (w_draw_x < w_total_x);
    end

    // Row of count cells, one per group
    assign w_link[0] = w_entry;

    for (genvar g = 0; g < MAX_GROUPS; g++) begin : g_cell
        wcs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_link[g]),
            .o_tok   (w_link[g+1])
        );
    end

    assign w_exit = w_link[MAX_GROUPS];

    // Settle the total: drop the replaced count, add the new one
    always_comb begin
        n_total = r_total;
        if (w_exit.valid && w_exit.hit) begin
            n_total = r_total - TOT_W'(w_exit.old) + TOT_W'(w_exit.cnt);
        end
    end

    assign w_new_total_x = TOTX_W'(n_total);
    assign w_grp_x       = GRPX_W'(w_exit.grp);
    assign w_off_x       = OFFX_W'(w_exit.off);

    // Advance the finished beat into the output register when it is free
    assign w_move = r_fin_v && (!r_out_v || i_ready);
    assign w_prop = r_rate * r_fin_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_total <= '0;
            r_rate  <= RATE_W'(65536);
            r_fin_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rate <= i_cfg_wdata;
            end
            r_total <= n_total;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_move) begin
                r_busy <= 1'b0;
            end
            if (w_exit.valid) begin
                r_fin_v <= 1'b1;
            end else if (w_move) begin
                r_fin_v <= 1'b0;
            end
            if (w_move) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        if (w_exit.valid) begin
            r_fin_total <= w_new_total_x[TOTO_W-1:0];
            r_fin_grp   <= w_grp_x[GRPO_W-1:0];
            r_fin_off   <= w_off_x[OFFO_W-1:0];
            r_fin_err   <= (w_exit.act == ACT_SELECT) && !w_exit.found;
        end
        if (w_move) begin
            o_total_count     <= r_fin_total;
            o_propensity      <= w_prop;
            o_chosen_group    <= r_fin_grp;
            o_offset_in_group <= r_fin_off;
            o_draw_error      <= r_fin_err;
        end
    end

    assign o_valid = r_out_v;

    // Checks
    `WCS_ASSERT_IMPL(a_no_overlap, w_accept, !w_exit.valid && !r_fin_v)
    `WCS_ASSERT_NEXT(a_busy_after_accept, w_accept, r_busy)
    `WCS_ASSERT_IMPL(a_fin_while_busy, r_fin_v, r_busy)
    `WCS_ASSERT_IMPL(a_err_zero_fields, o_valid && o_draw_error,
        o_chosen_group == '0 && o_offset_in_group == '0)

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted count selector testbench
// Self-checking bench: directed and random set/select beats against a local
// predictor of the count table, running total and rate, with random idling.
// ----------------------------------------------------------------------------
module tb_top;
    import wcs_pkg::*;

    // One beat in flight at a time
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_GAP      = 24;
    localparam int CYCLE_LIMIT  = 2000000;

    // One result beat as the block reports it
    typedef struct packed {
        logic [TOTO_W-1:0] tot;
        logic [PROP_W-1:0] prop;
        logic [GRPO_W-1:0] grp;
        logic [OFFO_W-1:0] off;
        logic              err;
    } t_wcs_report;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_action;
    logic [IDX_W-1:0]    i_group_index;
    logic [CNTIN_W-1:0]  i_group_count;
    logic [DRAW_W-1:0]   i_draw_value;
    logic                o_valid;
    logic                i_ready;
    logic [TOTO_W-1:0]   o_total_count;
    logic [PROP_W-1:0]   o_propensity;
    logic [GRPO_W-1:0]   o_chosen_group;
    logic [OFFO_W-1:0]   o_offset_in_group;
    logic                o_draw_error;
    logic                i_cfg_we;
    logic [RATE_W-1:0]   i_cfg_wdata;

    // Shadow of the block state, updated as each input beat is accepted
    logic [COUNT_BITS-1:0] tally_table [MAX_GROUPS];
    logic [TOTO_W-1:0]     tally_sum;
    logic [RATE_W-1:0]     rate_shadow;

    // Reports still owed by the block, oldest first
    t_wcs_report pending_reports [$];

    // Idling knobs, in percent per cycle
    int send_idle_pct;
    int recv_stall_pct;

    int mismatch_count;
    int cycle_count;
    int set_beats;
    int select_beats;
    int miss_beats;
    int reports_checked;
    logic [TOTO_W-1:0] peak_total;

    weighted_count_selector uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_action          (i_action),
        .i_group_index     (i_group_index),
        .i_group_count     (i_group_count),
        .i_draw_value      (i_draw_value),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_total_count     (o_total_count),
        .o_propensity      (o_propensity),
        .o_chosen_group    (o_chosen_group),
        .o_offset_in_group (o_offset_in_group),
        .o_draw_error      (o_draw_error),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d reports outstanding",
                   cycle_count, pending_reports.size());
            $display("FAIL weighted_count_selector");
            $finish;
        end
    end

    // Result side: drop ready at random per the stall knob
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Predictor: apply one accepted beat to the shadow state and return the
    // report the block must produce for it.
    // ------------------------------------------------------------------------
    function automatic t_wcs_report predict_report(input t_action act,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic [CNTIN_W-1:0] cnt,
                                                   input logic [DRAW_W-1:0] draw);
        t_wcs_report rpt;
        logic [DRAW_W-1:0] rem;
        logic [63:0] product;
        logic found;
        rpt = '0;
        if (act == ACT_SET) begin
            set_beats++;
            // Replace the group's count and patch the total by the difference
            if (idx < MAX_GROUPS) begin
                tally_sum = tally_sum - tally_table[idx] + cnt[COUNT_BITS-1:0];
                tally_table[idx] = cnt[COUNT_BITS-1:0];
            end
        end else begin
            select_beats++;
            if (draw >= tally_sum) begin
                // Draw off the end of the wheel, including an empty table
                rpt.err = 1'b1;
                miss_beats++;
            end else begin
                // Walk from group 0; empty groups never absorb the draw
                rem = draw;
                found = 1'b0;
                for (int g = 0; g < MAX_GROUPS; g++) begin
                    if (!found) begin
                        if (rem < tally_table[g]) begin
                            found = 1'b1;
                            rpt.grp = g[GRPO_W-1:0];
                            rpt.off = rem[OFFO_W-1:0];
                        end else begin
                            rem = rem - tally_table[g];
                        end
                    end
                end
            end
        end
        if (tally_sum > peak_total)
            peak_total = tally_sum;
        // Exact product, 16 fractional bits kept, nothing rounded
        product  = 64'(rate_shadow) * 64'(tally_sum);
        rpt.tot  = tally_sum;
        rpt.prop = product[PROP_W-1:0];
        return rpt;
    endfunction

    // ------------------------------------------------------------------------
    // Checker: compare every result beat with the oldest pending report.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_wcs_report want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected result beat: total_count %0d", o_total_count);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                reports_checked++;
                if (o_total_count !== want.tot) begin
                    $error("total_count: expected %0d, actual %0d", want.tot, o_total_count);
                    mismatch_count++;
                end
                if (o_propensity !== want.prop) begin
                    $error("propensity: expected %0d, actual %0d", want.prop, o_propensity);
                    mismatch_count++;
                end
                if (o_chosen_group !== want.grp) begin
                    $error("chosen_group: expected %0d, actual %0d", want.grp, o_chosen_group);
                    mismatch_count++;
                end
                if (o_offset_in_group !== want.off) begin
                    $error("offset_in_group: expected %0d, actual %0d",
                           want.off, o_offset_in_group);
                    mismatch_count++;
                end
                if (o_draw_error !== want.err) begin
                    $error("draw_error: expected %0d, actual %0d", want.err, o_draw_error);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Send one input beat. Entered at a clock edge; returns at the edge where
    // the beat is accepted, with valid still high. The caller either sends the
    // next beat in the same step (back to back) or calls drain to drop valid.
    // ------------------------------------------------------------------------
    task automatic send_beat(input t_action act, input logic [IDX_W-1:0] idx,
                             input logic [CNTIN_W-1:0] cnt,
                             input logic [DRAW_W-1:0] draw);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= act;
        i_group_index <= idx;
        i_group_count <= cnt;
        i_draw_value  <= draw;
        // Hold the beat until the block takes it
        do @(posedge i_clk); while (o_ready !== 1'b1);
        pending_reports.push_back(predict_report(act, idx, cnt, draw));
    endtask

    // Drop valid, wait out every pending report, then let the pipe settle
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the rate register; only called with the block idle
    task automatic load_rate(input logic [RATE_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rate_shadow = value;
    endtask

    // Selects on an empty table all miss; reset rate still in effect
    task automatic test_empty_table();
        send_beat(ACT_SELECT, 6'd0, 16'd0, 22'd0);
        send_beat(ACT_SELECT, 6'd63, 16'hFFFF, 22'h3FFFFF);
        send_beat(ACT_SET, 6'd0, 16'd0, 22'd0);
        send_beat(ACT_SELECT, 6'd0, 16'd0, 22'd0);
        drain();
    endtask

    // Extreme counts and draws at the edges of groups and of the total
    task automatic test_table_edges();
        send_beat(ACT_SET, 6'd0, 16'hFFFF, 22'h3FFFFF);
        send_beat(ACT_SET, 6'd63, 16'd1, 22'd0);
        send_beat(ACT_SELECT, 6'd0, 16'd0, 22'd0);
        send_beat(ACT_SELECT, 6'd0, 16'd0, 22'h00FFFE);
        send_beat(ACT_SELECT, 6'd0, 16'd0, 22'h00FFFF);   // first item of group 63
        send_beat(ACT_SELECT, 6'd0, 16'd0, 22'h010000);   // equal to total
        send_beat(ACT_SELECT, 6'h2A, 16'h5555, 22'h2AAAAA);
        drain();
    endtask

    // Empty groups in front of and between live ones are skipped
    task automatic test_zero_skip();
        send_beat(ACT_SET, 6'd0, 16'd0, 22'd0);
        send_beat(ACT_SET, 6'd31, 16'd2, 22'd0);
        send_beat(ACT_SET, 6'd62, 16'h8000, 22'd0);
        send_beat(ACT_SELECT, 6'd0, 16'd0, 22'd0);
        send_beat(ACT_SELECT, 6'd0, 16'd0, 22'd1);
        send_beat(ACT_SELECT, 6'd0, 16'd0, 22'd2);
        send_beat(ACT_SELECT, 6'd0, 16'd0, 22'h008001);
        send_beat(ACT_SELECT, 6'd0, 16'd0, 22'h008002);
        drain();
    endtask

    // Fill every group to the top: largest total and propensity
    task automatic test_full_table();
        logic [IDX_W-1:0] mix;
        load_rate(32'hFFFF_FFFF);
        mix = IDX_W'($urandom_range(63));
        for (int g = 0; g < MAX_GROUPS; g++)
            send_beat(ACT_SET, IDX_W'(g) ^ mix, 16'hFFFF, DRAW_W'($urandom));
        send_beat(ACT_SELECT, 6'd0, 16'd0, 22'd0);
        send_beat(ACT_SELECT, 6'd0, 16'd0, DRAW_W'(tally_sum - 1));
        send_beat(ACT_SELECT, 6'd0, 16'd0, tally_sum);
        send_beat(ACT_SELECT, 6'd0, 16'd0, 22'h3FFFFF);
        for (int k = 0; k < 6; k++)
            send_beat(ACT_SELECT, IDX_W'($urandom), CNTIN_W'($urandom),
                      DRAW_W'($urandom_range(int'(tally_sum) - 1, 0)));
        drain();
    endtask

    // Random sets and mostly in-range selects under one rate and idling mix
    task automatic test_random_traffic(input logic [RATE_W-1:0] rate, input int send_pct,
                                       input int recv_pct, input int n_beats);
        logic [CNTIN_W-1:0] cnt;
        logic [DRAW_W-1:0] draw;
        int pick;
        load_rate(rate);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int k = 0; k < n_beats; k++) begin
            pick = $urandom_range(9);
            if ($urandom_range(1) == 0) begin
                case (pick)
                    0:       cnt = '0;
                    1:       cnt = '1;
                    2, 3, 4: cnt = CNTIN_W'($urandom_range(15, 1));
                    default: cnt = CNTIN_W'($urandom);
                endcase
                send_beat(ACT_SET, IDX_W'($urandom), cnt, DRAW_W'($urandom));
            end else begin
                if (tally_sum == 0 || pick == 0)
                    draw = tally_sum + DRAW_W'($urandom_range(3));
                else if (pick == 1)
                    draw = DRAW_W'($urandom);
                else if (pick == 2)
                    draw = DRAW_W'(tally_sum - 1);
                else
                    draw = DRAW_W'($urandom_range(int'(tally_sum) - 1, 0));
                send_beat(ACT_SELECT, IDX_W'($urandom), CNTIN_W'($urandom), draw);
            end
        end
        drain();
    endtask

    initial begin
        // Known values on every input from time zero
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_action      <= ACT_SET;
        i_group_index <= '0;
        i_group_count <= '0;
        i_draw_value  <= '0;
        i_ready       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        for (int g = 0; g < MAX_GROUPS; g++)
            tally_table[g] = '0;
        tally_sum       = '0;
        rate_shadow     = 32'h0001_0000;
        peak_total      = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        set_beats       = 0;
        select_beats    = 0;
        miss_beats      = 0;
        reports_checked = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_table_edges();
        test_zero_skip();
        test_full_table();
        test_random_traffic(32'd0, 0, 0, 255);
        test_random_traffic(RATE_W'($urandom), 73, 0, 255);
        test_random_traffic(32'd1, 0, 73, 255);
        test_random_traffic(RATE_W'($urandom), 31, 31, 255);

        if (pending_reports.size() != 0) begin
            $error("%0d expected reports never arrived", pending_reports.size());
            mismatch_count++;
        end
        $display("Covered %0d set and %0d select beats (%0d off-wheel draws), %0d reports checked",
                 set_beats, select_beats, miss_beats, reports_checked);
        $display("Rates reset/zero/one/all-ones/random, peak total %0d, four idling mixes",
                 peak_total);
        if (mismatch_count == 0) begin
            $display("PASS weighted_count_selector");
        end else begin
            $display("FAIL weighted_count_selector");
        end
        $finish;
    end

endmodule
